// File: rtl/core/drgq_pkg.sv
`default_nettype none
package drgq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_ISSUE_DEF   = 16;
  localparam int ROW_BITS_DEF    = 16;
  localparam int TAG_BITS_DEF    = 16;

  localparam int RKL_W     = 6;
  localparam int AGE_W     = 11;
  localparam int CAP_W     = 6;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [RKL_W-1:0] RKL_RESET = 6'd8;
  localparam logic [AGE_W-1:0] AGE_RESET = 11'd1000;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  localparam logic [AGE_W-1:0] AGE_MAX   = 11'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_KEY_LIMIT  = 2'd0,
    CFG_AGE_LIMIT      = 2'd1,
    CFG_QUEUE_CAPACITY = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// File: rtl/core/drgq_front.sv
`default_nettype none
module drgq_front #(
  parameter int ROW_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  req_valid,
  input  wire logic [TAG_BITS-1:0]   req_tag,
  input  wire logic                  pseudo_channel,
  input  wire logic [1:0]            bank_group,
  input  wire logic [1:0]            bank_index,
  input  wire logic [ROW_BITS-1:0]   row_index,
  input  wire logic                  dram_ready,
  output logic                       tick_valid,
  input  wire logic                  tick_pop,
  output logic                       tick_req,
  output logic [TAG_BITS-1:0]        tick_tag,
  output logic [ROW_BITS+4:0]        tick_key,
  output logic                       tick_ready
);
  import drgq_pkg::*;

  localparam int KEY_W = ROW_BITS + 5;
  localparam int W = 2 + TAG_BITS + KEY_W;

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic [W-1:0] beat;

  // The row key orders pseudo channel, bank group, bank and row from the top down.
  assign beat = {req_valid, dram_ready, req_tag,
                 pseudo_channel, bank_group, bank_index, row_index};

  assign full       = (cnt == 2'd2);
  assign tick_valid = (cnt != 2'd0);
  assign {tick_req, tick_ready, tick_tag, tick_key} = slot[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wp] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (tick_pop && tick_valid) rp <= ~rp;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((tick_pop && tick_valid) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/drgq_resq.sv
`default_nettype none
module drgq_resq #(
  parameter int TAG_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                res_push,
  input  wire logic                res_acc,
  input  wire logic                res_valid,
  input  wire logic [TAG_BITS-1:0] res_tag,
  input  wire logic                res_last,
  output logic                     res_full,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     accepted,
  output logic                     issue_valid,
  output logic [TAG_BITS-1:0]      issue_tag,
  output logic                     last_of_tick
);
  import drgq_pkg::*;

  localparam int W = TAG_BITS + 3;

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign res_full = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign {accepted, issue_valid, issue_tag, last_of_tick} = slot[rp];

  always_ff @(posedge clk) begin
    if (res_push && !res_full) begin
      slot[wp] <= {res_acc, res_valid, res_tag, res_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (res_push && !res_full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      cnt <= cnt + 2'((res_push && !res_full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/drgq_back.sv
`default_nettype none
module drgq_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int MAX_ISSUE   = 16,
  parameter int ROW_BITS    = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire drgq_pkg::cfg_wr_t     cfg,
  input  wire logic                  tick_valid,
  output logic                       tick_pop,
  input  wire logic                  tick_req,
  input  wire logic [TAG_BITS-1:0]   tick_tag,
  input  wire logic [ROW_BITS+4:0]   tick_key,
  input  wire logic                  tick_ready,
  output logic                       res_push,
  output logic                       res_acc,
  output logic                       res_valid,
  output logic [TAG_BITS-1:0]        res_tag,
  output logic                       res_last,
  input  wire logic                  res_full
);
  import drgq_pkg::*;

  localparam int KEY_W = ROW_BITS + 5;
  localparam int IW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = $clog2(MAX_ISSUE + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_FRD, S_FCMP, S_ENT, S_AGE0, S_K0, S_K1, S_K1D, S_RRD, S_RWR,
    S_BUD, S_ISS, S_POPR, S_POPD, S_EMIT, S_KRD, S_KCMP, S_DRD, S_DWR, S_NONE
  } state_t;

  state_t state;

  logic [RKL_W-1:0] rkl;
  logic [AGE_W-1:0] agel;
  logic [CAP_W-1:0] cap;

  // Two banks of entries; a reorder pass copies from the live bank into the other.
  logic [TAG_BITS-1:0] ent_tag [2][QUEUE_DEPTH];
  logic [KEY_W-1:0]    ent_key [2][QUEUE_DEPTH];
  logic [AGE_W-1:0]    ent_age [2][QUEUE_DEPTH];
  logic [KEY_W-1:0]    kmem_key [QUEUE_DEPTH];
  logic [CW-1:0]       kmem_pend [QUEUE_DEPTH];

  logic [TAG_BITS-1:0] erd_tag;
  logic [KEY_W-1:0]    erd_key;
  logic [AGE_W-1:0]    erd_age;
  logic [KEY_W-1:0]    krd_key;
  logic [CW-1:0]       krd_pend;

  logic                ewe;
  logic                ewb;
  logic [IW-1:0]       ewa;
  logic [TAG_BITS-1:0] ewd_tag;
  logic [KEY_W-1:0]    ewd_key;
  logic [AGE_W-1:0]    ewd_age;
  logic [IW-1:0]       era;
  logic                kwe;
  logic [IW-1:0]       kwa;
  logic [KEY_W-1:0]    kwd_key;
  logic [CW-1:0]       kwd_pend;
  logic [IW-1:0]       kra;

  logic                bank;
  logic [IW-1:0]       head;
  logic [CW-1:0]       count;
  logic [CW-1:0]       key_cnt;
  logic [CW-1:0]       budget;

  logic                t_ready;
  logic [TAG_BITS-1:0] t_tag;
  logic [KEY_W-1:0]    t_key;
  logic                acc;
  logic [CW-1:0]       j;
  logic [CW-1:0]       i;
  logic [KEY_W-1:0]    k0;
  logic [KEY_W-1:0]    k1;
  logic [CW-1:0]       p0;
  logic [CW-1:0]       p1;
  logic                two;
  logic [CW-1:0]       n0;
  logic [CW-1:0]       n1;
  logic [CW-1:0]       n2;
  logic [AGE_W-1:0]    front_age;
  logic [SW-1:0]       iss_cnt;
  logic [TAG_BITS-1:0] p_tag;
  logic [KEY_W-1:0]    p_key;
  logic                p_last;

  logic                acc_now;
  logic [CW-1:0]       dest;
  logic [AGE_W-1:0]    age_inc;
  logic [CW-1:0]       pend_dec;

  function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(o);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return IW'(s);
  endfunction

  assign acc_now = tick_req && (32'(count) < 32'(cap)) && (32'(count) < QUEUE_DEPTH);
  assign age_inc = (erd_age < AGE_MAX) ? erd_age + 1'b1 : erd_age;
  assign pend_dec = (krd_pend != '0) ? krd_pend - 1'b1 : krd_pend;

  always_comb begin
    if (erd_key == k0) dest = n0;
    else if (two && erd_key == k1) dest = p0 + n1;
    else dest = p0 + p1 + n2;
  end

  always_comb begin
    tick_pop  = 1'b0;
    res_push  = 1'b0;
    res_acc   = acc;
    res_valid = 1'b0;
    res_tag   = '0;
    res_last  = 1'b1;
    ewe = 1'b0; ewb = bank; ewa = '0;
    ewd_tag = t_tag; ewd_key = t_key; ewd_age = '0;
    era = head;
    kwe = 1'b0; kwa = IW'(j); kwd_key = t_key; kwd_pend = CW'(1);
    kra = IW'(j);
    case (state)
      S_IDLE: tick_pop = tick_valid;
      S_FRD: begin
        if (j == key_cnt) kwe = 1'b1;
      end
      S_FCMP: begin
        if (krd_key == t_key) begin
          kwe = 1'b1;
          kwd_pend = krd_pend + 1'b1;
        end
      end
      S_ENT: begin
        ewe = 1'b1;
        ewa = wrap_idx(head, count);
      end
      S_K0: kra = '0;
      S_K1: kra = IW'(1);
      S_RRD: era = wrap_idx(head, i);
      S_RWR: begin
        ewe = 1'b1;
        ewb = ~bank;
        ewa = IW'(dest);
        ewd_tag = erd_tag;
        ewd_key = erd_key;
        ewd_age = age_inc;
      end
      S_POPR: era = head;
      S_EMIT: begin
        res_push  = !res_full;
        res_valid = 1'b1;
        res_tag   = p_tag;
        res_last  = p_last;
      end
      S_KCMP: begin
        if (krd_key == p_key && pend_dec != '0) begin
          kwe = 1'b1;
          kwd_key = krd_key;
          kwd_pend = pend_dec;
        end
      end
      S_DRD: kra = IW'(j + 1'b1);
      S_DWR: begin
        kwe = 1'b1;
        kwd_key = krd_key;
        kwd_pend = krd_pend;
      end
      S_NONE: res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ewe) begin
      ent_tag[ewb][ewa] <= ewd_tag;
      ent_key[ewb][ewa] <= ewd_key;
      ent_age[ewb][ewa] <= ewd_age;
    end
    erd_tag <= ent_tag[bank][era];
    erd_key <= ent_key[bank][era];
    erd_age <= ent_age[bank][era];
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem_key[kwa]  <= kwd_key;
      kmem_pend[kwa] <= kwd_pend;
    end
    krd_key  <= kmem_key[kra];
    krd_pend <= kmem_pend[kra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rkl     <= RKL_RESET;
      agel    <= AGE_RESET;
      cap     <= CAP_RESET;
      bank    <= 1'b0;
      head    <= '0;
      count   <= '0;
      key_cnt <= '0;
      budget  <= '0;
    end else begin
      if (cfg.we) begin
        case (cfg.idx)
          CFG_ROW_KEY_LIMIT:  rkl  <= cfg.data[RKL_W-1:0];
          CFG_AGE_LIMIT:      agel <= cfg.data[AGE_W-1:0];
          CFG_QUEUE_CAPACITY: cap  <= cfg.data[CAP_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (tick_valid) begin
            t_ready <= tick_ready;
            t_tag   <= tick_tag;
            t_key   <= tick_key;
            acc     <= acc_now;
            j       <= '0;
            state   <= acc_now ? S_FRD : S_AGE0;
          end
        end
        S_FRD: begin
          if (j == key_cnt) begin
            key_cnt <= key_cnt + 1'b1;
            state   <= S_ENT;
          end else begin
            state <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (krd_key == t_key) begin
            state <= S_ENT;
          end else begin
            j     <= j + 1'b1;
            state <= S_FRD;
          end
        end
        S_ENT: begin
          count <= count + 1'b1;
          state <= S_AGE0;
        end
        S_AGE0: begin
          iss_cnt <= '0;
          state   <= (count == '0) ? S_ISS : S_K0;
        end
        S_K0: state <= S_K1;
        S_K1: begin
          k0    <= krd_key;
          p0    <= krd_pend;
          state <= S_K1D;
        end
        S_K1D: begin
          two <= (key_cnt > CW'(1));
          k1  <= krd_key;
          p1  <= (key_cnt > CW'(1)) ? krd_pend : '0;
          i   <= '0;
          n0  <= '0;
          n1  <= '0;
          n2  <= '0;
          state <= S_RRD;
        end
        S_RRD: state <= S_RWR;
        S_RWR: begin
          if (dest == '0) front_age <= age_inc;
          if (erd_key == k0) n0 <= n0 + 1'b1;
          else if (two && erd_key == k1) n1 <= n1 + 1'b1;
          else n2 <= n2 + 1'b1;
          i <= i + 1'b1;
          if (i + 1'b1 == count) begin
            bank  <= ~bank;
            head  <= '0;
            state <= S_BUD;
          end else begin
            state <= S_RRD;
          end
        end
        S_BUD: begin
          if (32'(key_cnt) > 32'(rkl)) budget <= p0;
          else if (front_age > agel) budget <= count;
          state <= S_ISS;
        end
        S_ISS: begin
          if (t_ready && count != '0 && budget != '0 && 32'(iss_cnt) < MAX_ISSUE) begin
            state <= S_POPR;
          end else if (iss_cnt == '0) begin
            state <= S_NONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_POPR: state <= S_POPD;
        S_POPD: begin
          p_tag   <= erd_tag;
          p_key   <= erd_key;
          head    <= wrap_idx(head, CW'(1));
          count   <= count - 1'b1;
          budget  <= budget - 1'b1;
          iss_cnt <= iss_cnt + 1'b1;
          p_last  <= (32'(iss_cnt) + 1 == MAX_ISSUE) || !t_ready ||
                     count == CW'(1) || budget == CW'(1);
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full) begin
            j     <= '0;
            state <= S_KRD;
          end
        end
        S_KRD: state <= (j == key_cnt) ? S_ISS : S_KCMP;
        S_KCMP: begin
          if (krd_key == p_key) begin
            state <= (pend_dec == '0) ? S_DRD : S_ISS;
          end else begin
            j     <= j + 1'b1;
            state <= S_KRD;
          end
        end
        S_DRD: begin
          // Close the gap left by an emptied key, shifting each later key down one slot.
          if (j + 1'b1 >= key_cnt) begin
            key_cnt <= key_cnt - 1'b1;
            state   <= S_ISS;
          end else begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          j     <= j + 1'b1;
          state <= S_DRD;
        end
        S_NONE: begin
          if (!res_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dram_row_grouping_request_queue_unit.sv
`default_nettype none
// Open-row batching request queue for one DRAM channel. Each beat pushed in is one
// interconnect tick; it gives one or more result beats (one per issued request, or a
// single idle beat), the final one marked by last_of_tick. A tick is handled by one
// sequencer walking entry and key memories that each have one read and one write port.
// An accepted request is compared with each known row key, and its key is added when
// it is new. A non-empty queue then goes through an aging and reordering pass over
// every queued entry. Each issued request looks up its row key and, when that key runs
// out, shifts the later keys down; a full result queue stalls the sequencer. A two-beat
// queue at each side lets the input side and the result side stall independently of
// the sequencer.
module dram_row_grouping_request_queue_unit #(
  parameter int QUEUE_DEPTH = drgq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_ISSUE   = drgq_pkg::MAX_ISSUE_DEF,
  parameter int ROW_BITS    = drgq_pkg::ROW_BITS_DEF,
  parameter int TAG_BITS    = drgq_pkg::TAG_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              req_valid,
  input  wire logic [TAG_BITS-1:0]               req_tag,
  input  wire logic                              pseudo_channel,
  input  wire logic [1:0]                        bank_group,
  input  wire logic [1:0]                        bank_index,
  input  wire logic [ROW_BITS-1:0]               row_index,
  input  wire logic                              dram_ready,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   accepted,
  output logic                                   issue_valid,
  output logic [TAG_BITS-1:0]                    issue_tag,
  output logic                                   last_of_tick,
  input  wire logic                              cfg_we,
  input  wire logic [drgq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drgq_pkg::CFG_W-1:0]        cfg_data
);
  import drgq_pkg::*;

  cfg_wr_t              cfg;
  logic                 tick_valid;
  logic                 tick_pop;
  logic                 tick_req;
  logic [TAG_BITS-1:0]  tick_tag;
  logic [ROW_BITS+4:0]  tick_key;
  logic                 tick_ready;
  logic                 res_push;
  logic                 res_acc;
  logic                 res_valid;
  logic [TAG_BITS-1:0]  res_tag;
  logic                 res_last;
  logic                 res_full;

  assign cfg = '{we: cfg_we, idx: cfg_index, data: cfg_data};

  drgq_front #(.ROW_BITS(ROW_BITS), .TAG_BITS(TAG_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_valid(req_valid), .req_tag(req_tag), .pseudo_channel(pseudo_channel),
    .bank_group(bank_group), .bank_index(bank_index), .row_index(row_index),
    .dram_ready(dram_ready),
    .tick_valid(tick_valid), .tick_pop(tick_pop), .tick_req(tick_req),
    .tick_tag(tick_tag), .tick_key(tick_key), .tick_ready(tick_ready)
  );

  drgq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .MAX_ISSUE(MAX_ISSUE),
    .ROW_BITS(ROW_BITS), .TAG_BITS(TAG_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .tick_valid(tick_valid), .tick_pop(tick_pop), .tick_req(tick_req),
    .tick_tag(tick_tag), .tick_key(tick_key), .tick_ready(tick_ready),
    .res_push(res_push), .res_acc(res_acc), .res_valid(res_valid),
    .res_tag(res_tag), .res_last(res_last), .res_full(res_full)
  );

  drgq_resq #(.TAG_BITS(TAG_BITS)) u_resq (
    .clk(clk), .rst(rst),
    .res_push(res_push), .res_acc(res_acc), .res_valid(res_valid),
    .res_tag(res_tag), .res_last(res_last), .res_full(res_full),
    .empty(empty), .pop(pop),
    .accepted(accepted), .issue_valid(issue_valid),
    .issue_tag(issue_tag), .last_of_tick(last_of_tick)
  );

endmodule
`default_nettype wire

// File: tb/tb_dram_row_grouping_request_queue_unit.sv
`timescale 1ns / 1ps
module tb_dram_row_grouping_request_queue_unit;
  import drgq_pkg::*;

  localparam int DEPTH      = 32;
  localparam int ISSUE_MAX  = 16;
  localparam int STALL_MAX  = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int EXP_DEPTH  = 1024;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct packed {
    logic        acc;
    logic        vld;
    logic [15:0] tag;
    logic        last;
  } issue_beat_t;

  typedef struct packed {
    logic        rv;
    logic [15:0] tag;
    logic        pc;
    logic [1:0]  bg;
    logic [1:0]  bk;
    logic [15:0] row;
    logic        rdy;
    logic        typed;
    issue_beat_t res;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic req_valid = 1'b0;
  logic [15:0] req_tag = '0;
  logic pseudo_channel = 1'b0;
  logic [1:0] bank_group = '0;
  logic [1:0] bank_index = '0;
  logic [15:0] row_index = '0;
  logic dram_ready = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic accepted;
  logic issue_valid;
  logic [15:0] issue_tag;
  logic last_of_tick;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  dram_row_grouping_request_queue_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_valid(req_valid),
    .req_tag(req_tag), .pseudo_channel(pseudo_channel), .bank_group(bank_group),
    .bank_index(bank_index), .row_index(row_index), .dram_ready(dram_ready),
    .empty(empty), .pop(pop), .accepted(accepted), .issue_valid(issue_valid),
    .issue_tag(issue_tag), .last_of_tick(last_of_tick), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scheduler mirror.
  logic [5:0]  m_rkl;
  logic [10:0] m_age_lim;
  logic [5:0]  m_cap;
  logic [15:0] q_tag [DEPTH];
  logic [20:0] q_key [DEPTH];
  logic [10:0] q_age [DEPTH];
  int          q_cnt;
  logic [20:0] k_ord [DEPTH];
  int          k_pend [DEPTH];
  int          k_cnt;
  int          budget;

  // Expected result beats, oldest at exp_rd.
  issue_beat_t exp_buf [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int snd_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_go = 0;
  bit hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  function automatic void exp_add(issue_beat_t b);
    exp_buf[exp_wr % EXP_DEPTH] = b;
    exp_wr++;
  endfunction

  function automatic int key_slot(logic [20:0] key);
    for (int i = 0; i < k_cnt; i++)
      if (k_ord[i] == key) return i;
    return k_cnt;
  endfunction

  function automatic void group_rows();
    logic [15:0] t_tag [DEPTH];
    logic [20:0] t_key [DEPTH];
    logic [10:0] t_age [DEPTH];
    logic [20:0] k0, k1;
    bit two, take;
    int n;
    n = 0;
    k0 = k_ord[0];
    two = k_cnt > 1;
    k1 = two ? k_ord[1] : k0;
    for (int pass = 0; pass < 3; pass++)
      for (int i = 0; i < q_cnt; i++) begin
        if (pass == 0) take = q_key[i] == k0;
        else if (pass == 1) take = two && q_key[i] == k1;
        else take = !(q_key[i] == k0 || (two && q_key[i] == k1));
        if (take) begin
          t_tag[n] = q_tag[i]; t_key[n] = q_key[i]; t_age[n] = q_age[i];
          n++;
        end
      end
    for (int i = 0; i < n; i++) begin
      q_tag[i] = t_tag[i]; q_key[i] = t_key[i]; q_age[i] = t_age[i];
    end
  endfunction

  function automatic logic [15:0] issue_front();
    logic [15:0] tag;
    logic [20:0] key;
    int idx;
    tag = q_tag[0];
    key = q_key[0];
    for (int i = 0; i + 1 < q_cnt; i++) begin
      q_tag[i] = q_tag[i+1]; q_key[i] = q_key[i+1]; q_age[i] = q_age[i+1];
    end
    q_cnt--;
    if (budget > 0) budget--;
    idx = key_slot(key);
    if (idx < k_cnt) begin
      if (k_pend[idx] > 0) k_pend[idx]--;
      if (k_pend[idx] == 0) begin
        for (int j = idx; j + 1 < k_cnt; j++) begin
          k_ord[j] = k_ord[j+1]; k_pend[j] = k_pend[j+1];
        end
        k_cnt--;
      end
    end
    return tag;
  endfunction

  // Works out the result beats of one tick and queues them.
  function automatic void predict_tick(tick_row_t r);
    logic [20:0] key;
    logic acc;
    int idx, n;
    issue_beat_t b;
    acc = 1'b0;
    n = 0;
    if (r.rv && q_cnt < m_cap && q_cnt < DEPTH) begin
      key = {r.pc, r.bg, r.bk, r.row};
      idx = key_slot(key);
      if (idx < k_cnt) k_pend[idx]++;
      else begin
        k_ord[k_cnt] = key; k_pend[k_cnt] = 1; k_cnt++;
      end
      q_tag[q_cnt] = r.tag; q_key[q_cnt] = key; q_age[q_cnt] = '0;
      q_cnt++;
      acc = 1'b1;
    end
    if (q_cnt > 0 && k_cnt > 0) begin
      for (int i = 0; i < q_cnt; i++)
        if (q_age[i] < AGE_MAX) q_age[i]++;
      group_rows();
      if (k_cnt > m_rkl) budget = k_pend[0];
      else if (q_age[0] > m_age_lim) budget = q_cnt;
    end
    if (r.rdy)
      for (int t = 0; t < ISSUE_MAX; t++) begin
        if (q_cnt == 0 || budget == 0) break;
        b.acc = acc; b.vld = 1'b1; b.tag = issue_front(); b.last = 1'b0;
        exp_add(b);
        n++;
      end
    if (n == 0) begin
      b.acc = acc; b.vld = 1'b0; b.tag = '0; b.last = 1'b1;
      exp_add(b);
    end else begin
      exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    end
  endfunction

  // Result side: checks each popped beat and drives pop for the next edge.
  always @(posedge clk) begin
    issue_beat_t e;
    if (!rst) begin
      if ((pop && !empty) || (push && !full)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("%0t: watchdog expired", $time);
        $display("dram_row_grouping_request_queue_unit verification failed");
        $finish;
      end
      if (pop && !empty) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected beat acc=%0b vld=%0b tag=%h last=%0b", $time,
                   accepted, issue_valid, issue_tag, last_of_tick);
          errors++;
        end else begin
          e = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (e.acc !== accepted) begin
            $display("%0t: accepted exp %0b got %0b", $time, e.acc, accepted); errors++;
          end
          if (e.vld !== issue_valid) begin
            $display("%0t: issue_valid exp %0b got %0b", $time, e.vld, issue_valid);
            errors++;
          end
          if (e.tag !== issue_tag) begin
            $display("%0t: issue_tag exp %h got %h", $time, e.tag, issue_tag); errors++;
          end
          if (e.last !== last_of_tick) begin
            $display("%0t: last_of_tick exp %0b got %0b", $time, e.last, last_of_tick);
            errors++;
          end
        end
      end
    end
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_LEN;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_tick(tick_row_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_valid <= r.rv; req_tag <= r.tag; pseudo_channel <= r.pc;
    bank_group <= r.bg; bank_index <= r.bk; row_index <= r.row; dram_ready <= r.rdy;
    do @(posedge clk); while (full);
    predict_tick(r);
    if (r.typed) exp_buf[(exp_wr - 1) % EXP_DEPTH] = r.res;
  endtask

  task automatic drain_wait();
    push <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    // The sequencer may still be shifting keys after the last beat has left.
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROW_KEY_LIMIT:  m_rkl = val[5:0];
      CFG_AGE_LIMIT:      m_age_lim = val[10:0];
      CFG_QUEUE_CAPACITY: m_cap = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_W-1:0] rkl, logic [CFG_W-1:0] age,
                          logic [CFG_W-1:0] cap);
    drain_wait();
    write_reg(CFG_ROW_KEY_LIMIT, rkl);
    write_reg(CFG_AGE_LIMIT, age);
    write_reg(CFG_QUEUE_CAPACITY, cap);
  endtask

  function automatic tick_row_t rand_tick();
    tick_row_t r;
    r = '0;
    r.rv  = $urandom_range(99) < 80;
    r.tag = 16'($urandom);
    // Mostly a small pool of rows so that keys repeat and groups form.
    if ($urandom_range(9) < 8) begin
      r.pc = 1'($urandom_range(1) & $urandom_range(1));
      r.bg = 2'($urandom_range(1));
      r.bk = 2'($urandom_range(1));
      r.row = ($urandom_range(2) != 0) ? 16'(16'hFFFF - $urandom_range(1)) :
                                         16'($urandom_range(1));
    end else begin
      r.pc = 1'($urandom); r.bg = 2'($urandom); r.bk = 2'($urandom);
      r.row = 16'($urandom);
    end
    r.rdy = $urandom_range(99) < 70;
    return r;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_tick(rand_tick());
  endtask

  tick_row_t directed [$];

  function automatic tick_row_t mk(bit rv, logic [15:0] tag, bit pc, logic [1:0] bg,
                                   logic [1:0] bk, logic [15:0] row, bit rdy);
    tick_row_t r;
    r = '0;
    r.rv = rv; r.tag = tag; r.pc = pc; r.bg = bg; r.bk = bk; r.row = row; r.rdy = rdy;
    return r;
  endfunction

  initial begin
    tick_row_t r;
    m_rkl = RKL_RESET; m_age_lim = AGE_RESET; m_cap = CAP_RESET;
    q_cnt = 0; k_cnt = 0; budget = 0;

    // Little state after reset, so the first rows are typed idle beats.
    r = mk(1, 16'hFFFF, 1, 3, 3, 16'hFFFF, 0); r.typed = 1; r.res = '{1, 0, 0, 1};
    directed.push_back(r);
    r = mk(1, 16'h0000, 0, 0, 0, 16'h0000, 1); r.typed = 1; r.res = '{1, 0, 0, 1};
    directed.push_back(r);
    r = mk(0, 16'h1234, 0, 0, 0, 16'h0000, 1); r.typed = 1; r.res = '{0, 0, 0, 1};
    directed.push_back(r);
    // More keys than the limit drains the front group.
    for (int i = 1; i <= 8; i++)
      directed.push_back(mk(1, 16'(16'h0100 + i), i[0], i[2:1], i[1:0], 16'(i), i > 6));
    directed.push_back(mk(1, 16'hAAAA, 1, 3, 3, 16'hFFFF, 1));
    directed.push_back(mk(1, 16'h5555, 0, 0, 0, 16'h0000, 1));
    for (int i = 0; i < 6; i++) directed.push_back(mk(0, '0, 0, 0, 0, '0, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    snd_idle_pct = 17; rx_idle_pct = 52;
    foreach (directed[i]) send_tick(directed[i]);

    set_regs(3, 10, 32);
    run_random(90);
    // Leftover budget with an empty queue, then aging drains at the lowest limits.
    set_regs(0, 0, 1);
    snd_idle_pct = 52; rx_idle_pct = 17;
    run_random(80);
    // Upper bits of the data are dropped; the unused index selects nothing.
    set_regs(11'h7E0, 2047, 32);
    write_reg(cfg_idx_t'(CFG_NO_REG), 11'h7FF);
    snd_idle_pct = 0; rx_idle_pct = 0;
    run_random(60);
    set_regs(32, 2046, 0);
    run_random(20);
    set_regs(8, 30, 20);
    hold_go = ~hold_go;
    run_random(90);
    set_regs(2, 1000, 32);
    run_random(80);
    set_regs(5, 3, 7);
    run_random(60);

    drain_wait();
    repeat (200) @(posedge clk);
    if (errors == 0 && exp_wr == exp_rd)
      $display("dram_row_grouping_request_queue_unit verification clean");
    else
      $display("dram_row_grouping_request_queue_unit verification failed");
    $finish;
  end
endmodule

// File: sim.f
rtl/core/drgq_pkg.sv
rtl/core/drgq_front.sv
rtl/core/drgq_resq.sv
rtl/core/drgq_back.sv
rtl/core/dram_row_grouping_request_queue_unit.sv
tb/tb_dram_row_grouping_request_queue_unit.sv
